### hdl/depth_pixel_backprojection_macros.svh
// assertion macros for the depth pixel back-projection block
// used by the top level only, no other dependencies
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DPB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpb same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define DPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpb next-cycle check failed");

`endif

### hdl/dpb_pkg.sv
// shared types and constants of the depth pixel back-projection block
// no dependencies
`default_nettype none

package dpb_pkg;

  localparam int DEPTH_W    = 16;
  localparam int POINT_W    = 24;
  localparam int INV_W      = 24;
  localparam int INV_HALF_W = 12;
  localparam int CENTER_W   = 16;
  localparam int MARGIN_W   = 10;
  localparam int STEP_W     = 5;
  localparam int SIZE_W     = 12;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 28;
  localparam int STEP_MAX   = 16;

  // saturation limits of a signed 24-bit result, as magnitudes
  localparam int OUT_MAX     = 8388607;
  localparam int OUT_MIN_MAG = 8388608;

  localparam logic [INV_W-1:0]    RST_FOCAL_INV = 24'd16777;
  localparam logic [CENTER_W-1:0] RST_CENTER_X  = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y  = 16'd3840;
  localparam logic [MARGIN_W-1:0] RST_MARGIN    = 10'd0;
  localparam logic [STEP_W-1:0]   RST_STEP      = 5'd1;
  localparam logic [SIZE_W-1:0]   RST_WIDTH     = 12'd640;
  localparam logic [SIZE_W-1:0]   RST_HEIGHT    = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X_INV,
    CFG_FOCAL_Y_INV,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_BORDER_MARGIN,
    CFG_DECIMATION_STEP,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_D,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_FIN,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis_y;
  } cmd_t;

  typedef struct packed {
    logic keep;
  } status_t;

endpackage

`default_nettype wire

### hdl/dpb_if.sv
// valid/ready stream interfaces for depth words and point words
// depends on dpb_pkg
`default_nettype none

interface dpb_in_if;
  logic                          valid;
  logic                          ready;
  logic [dpb_pkg::DEPTH_W-1:0]   depth_raw;

  modport source(output valid, output depth_raw, input ready);
  modport sink(input valid, input depth_raw, output ready);
endinterface

interface dpb_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpb_pkg::POINT_W-1:0] point_x;
  logic signed [dpb_pkg::POINT_W-1:0] point_y;
  logic signed [dpb_pkg::POINT_W-1:0] point_z;

  modport source(output valid, output point_x, output point_y, output point_z, input ready);
  modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

### hdl/dpb_ctrl.sv
// sequencing controller: accepts depth words, steps the datapath through
// the multiply sequence of both axes and owns the result valid flag; uses dpb_pkg
`default_nettype none

module dpb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dpb_pkg::status_t status,
  output dpb_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = dpb_pkg::OP_NONE;
    cmd.axis_y    = axis_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op = dpb_pkg::OP_LOAD;
          if (status.keep) begin
            state_nxt = S_MUL_D;
            axis_nxt  = 1'b0;
          end
        end
      end
      S_MUL_D: begin
        cmd.op    = dpb_pkg::OP_MUL_D;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op    = dpb_pkg::OP_MUL_LO;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op    = dpb_pkg::OP_MUL_HI;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = dpb_pkg::OP_ACC;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = dpb_pkg::OP_FIN;
        if (axis_r) begin
          state_nxt = S_EMIT;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = S_MUL_D;
        end
      end
      S_EMIT: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.op        = dpb_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/dpb_datapath.sv
// datapath: configuration registers, raster tracking and keep test, shared
// multiplier with accumulator, rounding and saturation, result registers; uses dpb_pkg
`default_nettype none

module dpb_datapath #(
  parameter int MAX_SIDE          = 2048,
  parameter int FORWARD_AXIS_IS_Y = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [dpb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [dpb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic [dpb_pkg::DEPTH_W-1:0]           in_depth_raw,
  input  wire dpb_pkg::cmd_t                         cmd,
  output dpb_pkg::status_t                           status,
  output logic signed [dpb_pkg::POINT_W-1:0]         point_x,
  output logic signed [dpb_pkg::POINT_W-1:0]         point_y,
  output logic signed [dpb_pkg::POINT_W-1:0]         point_z
);

  localparam int CW  = $clog2(MAX_SIDE);
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int EW  = (SW > dpb_pkg::SIZE_W) ? SW : dpb_pkg::SIZE_W;
  localparam int PW  = EW + 1;
  localparam int DW  = (CW + 4 > dpb_pkg::CENTER_W) ? CW + 4 : dpb_pkg::CENTER_W;
  localparam int PRW = DW + dpb_pkg::DEPTH_W;
  localparam int MW  = PRW + dpb_pkg::DEPTH_W;
  localparam int AW  = PRW + dpb_pkg::INV_W;
  localparam int RW  = AW + 1 - dpb_pkg::FRAC_W;
  localparam int PTW = dpb_pkg::POINT_W;

  localparam logic [EW-1:0] SIDE_LIMIT = EW'(MAX_SIDE);
  localparam logic [RW-1:0] POS_LIMIT  = RW'(dpb_pkg::OUT_MAX);
  localparam logic [RW-1:0] NEG_LIMIT  = RW'(dpb_pkg::OUT_MIN_MAG);
  localparam logic [AW:0]   ROUND_HALF = (AW + 1)'(1) << (dpb_pkg::FRAC_W - 1);

  // configuration registers
  logic [dpb_pkg::INV_W-1:0]    focal_x_inv_r;
  logic [dpb_pkg::INV_W-1:0]    focal_y_inv_r;
  logic [dpb_pkg::CENTER_W-1:0] center_x_r;
  logic [dpb_pkg::CENTER_W-1:0] center_y_r;
  logic [dpb_pkg::MARGIN_W-1:0] margin_r;
  logic [dpb_pkg::STEP_W-1:0]   step_r;
  logic [dpb_pkg::SIZE_W-1:0]   width_r;
  logic [dpb_pkg::SIZE_W-1:0]   height_r;

  // raster state
  logic [CW-1:0]               col_cnt_r;
  logic [CW-1:0]               row_cnt_r;
  logic [dpb_pkg::PHASE_W-1:0] col_phase_r;
  logic [dpb_pkg::PHASE_W-1:0] row_phase_r;

  // latched pixel and arithmetic registers
  logic [dpb_pkg::DEPTH_W-1:0] d_r;
  logic [CW-1:0]               u_r;
  logic [CW-1:0]               v_r;
  logic [MW-1:0]               mul_r;
  logic [PRW-1:0]              p_r;
  logic [AW-1:0]               acc_r;
  logic                        neg_r;
  logic [PTW-1:0]              res_x_r;
  logic [PTW-1:0]              res_y_r;
  logic [PTW-1:0]              pt_x_r;
  logic [PTW-1:0]              pt_y_r;
  logic [PTW-1:0]              pt_z_r;

  logic [EW-1:0]                w_eff;
  logic [EW-1:0]                h_eff;
  logic [dpb_pkg::STEP_W-1:0]   step_eff;
  logic [PW-1:0]                u_p;
  logic [PW-1:0]                v_p;
  logic [PW-1:0]                m_p;
  logic [PW-1:0]                w_p;
  logic [PW-1:0]                h_p;
  logic                         col_in;
  logic                         row_in;
  logic                         col_last;
  logic                         row_last;
  logic [dpb_pkg::PHASE_W-1:0]  col_phase_adv;
  logic [dpb_pkg::PHASE_W-1:0]  row_phase_adv;

  logic [CW-1:0]                pos;
  logic [DW-1:0]                pos16;
  logic [DW-1:0]                cen;
  logic [DW-1:0]                diff;
  logic                         neg_raw;
  logic                         negate;
  logic [dpb_pkg::INV_W-1:0]    inv;
  logic [PRW-1:0]               mul_a;
  logic [dpb_pkg::DEPTH_W-1:0]  mul_b;
  logic [MW-1:0]                mul_prod;
  logic [AW:0]                  rounded;
  logic [RW-1:0]                mag;
  logic [RW-1:0]                mag_clip;
  logic [PTW-1:0]               fin;
  logic [PTW-1:0]               depth_pt;

  function automatic logic [dpb_pkg::PHASE_W-1:0] next_phase(
    input logic [dpb_pkg::PHASE_W-1:0] ph,
    input logic [dpb_pkg::STEP_W-1:0]  step
  );
    logic [dpb_pkg::STEP_W-1:0] n;
    n = dpb_pkg::STEP_W'(ph) + dpb_pkg::STEP_W'(1);
    return (n >= step) ? '0 : n[dpb_pkg::PHASE_W-1:0];
  endfunction

  // effective sizes and step
  always_comb begin
    if (width_r == '0) begin
      w_eff = EW'(1);
    end else if (EW'(width_r) > SIDE_LIMIT) begin
      w_eff = SIDE_LIMIT;
    end else begin
      w_eff = EW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = EW'(1);
    end else if (EW'(height_r) > SIDE_LIMIT) begin
      h_eff = SIDE_LIMIT;
    end else begin
      h_eff = EW'(height_r);
    end
    if (step_r == '0) begin
      step_eff = dpb_pkg::STEP_W'(1);
    end else if (step_r > dpb_pkg::STEP_W'(dpb_pkg::STEP_MAX)) begin
      step_eff = dpb_pkg::STEP_W'(dpb_pkg::STEP_MAX);
    end else begin
      step_eff = step_r;
    end
  end

  assign u_p = PW'(col_cnt_r);
  assign v_p = PW'(row_cnt_r);
  assign m_p = PW'(margin_r);
  assign w_p = PW'(w_eff);
  assign h_p = PW'(h_eff);

  assign col_in   = (u_p >= m_p) && ((u_p + m_p) < w_p);
  assign row_in   = (v_p >= m_p) && ((v_p + m_p) < h_p);
  assign col_last = ((u_p + PW'(1)) >= w_p);
  assign row_last = ((v_p + PW'(1)) >= h_p);
  assign col_phase_adv = next_phase(col_phase_r, step_eff);
  assign row_phase_adv = next_phase(row_phase_r, step_eff);

  assign status.keep = col_in && row_in && (col_phase_r == '0) && (row_phase_r == '0)
                       && (in_depth_raw != '0);

  // operand selection for the shared multiplier
  assign pos     = cmd.axis_y ? v_r : u_r;
  assign pos16   = DW'({pos, 4'b0000});
  assign cen     = DW'(cmd.axis_y ? center_y_r : center_x_r);
  assign neg_raw = (pos16 < cen);
  assign diff    = neg_raw ? (cen - pos16) : (pos16 - cen);
  assign negate  = (FORWARD_AXIS_IS_Y != 0) && cmd.axis_y;
  assign inv     = cmd.axis_y ? focal_y_inv_r : focal_x_inv_r;

  always_comb begin
    case (cmd.op)
      dpb_pkg::OP_MUL_D: begin
        mul_a = PRW'(diff);
        mul_b = d_r;
      end
      dpb_pkg::OP_MUL_LO: begin
        mul_a = mul_r[PRW-1:0];
        mul_b = dpb_pkg::DEPTH_W'(inv[dpb_pkg::INV_HALF_W-1:0]);
      end
      dpb_pkg::OP_MUL_HI: begin
        mul_a = p_r;
        mul_b = dpb_pkg::DEPTH_W'(inv[dpb_pkg::INV_W-1:dpb_pkg::INV_HALF_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = MW'(mul_a) * MW'(mul_b);

  // round half away from zero on the magnitude, then saturate
  assign rounded = (AW + 1)'(acc_r) + ROUND_HALF;
  assign mag     = rounded[AW:dpb_pkg::FRAC_W];

  always_comb begin
    if (neg_r) begin
      mag_clip = (mag > NEG_LIMIT) ? NEG_LIMIT : mag;
      fin      = PTW'(0) - mag_clip[PTW-1:0];
    end else begin
      mag_clip = (mag > POS_LIMIT) ? POS_LIMIT : mag;
      fin      = mag_clip[PTW-1:0];
    end
  end

  assign depth_pt = PTW'(d_r);

  // configuration and raster state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_inv_r <= dpb_pkg::RST_FOCAL_INV;
      focal_y_inv_r <= dpb_pkg::RST_FOCAL_INV;
      center_x_r    <= dpb_pkg::RST_CENTER_X;
      center_y_r    <= dpb_pkg::RST_CENTER_Y;
      margin_r      <= dpb_pkg::RST_MARGIN;
      step_r        <= dpb_pkg::RST_STEP;
      width_r       <= dpb_pkg::RST_WIDTH;
      height_r      <= dpb_pkg::RST_HEIGHT;
      col_cnt_r     <= '0;
      row_cnt_r     <= '0;
      col_phase_r   <= '0;
      row_phase_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (dpb_pkg::cfg_idx_t'(cfg_index))
          dpb_pkg::CFG_FOCAL_X_INV:     focal_x_inv_r <= cfg_data;
          dpb_pkg::CFG_FOCAL_Y_INV:     focal_y_inv_r <= cfg_data;
          dpb_pkg::CFG_CENTER_X:        center_x_r <= cfg_data[dpb_pkg::CENTER_W-1:0];
          dpb_pkg::CFG_CENTER_Y:        center_y_r <= cfg_data[dpb_pkg::CENTER_W-1:0];
          dpb_pkg::CFG_BORDER_MARGIN:   margin_r   <= cfg_data[dpb_pkg::MARGIN_W-1:0];
          dpb_pkg::CFG_DECIMATION_STEP: step_r     <= cfg_data[dpb_pkg::STEP_W-1:0];
          dpb_pkg::CFG_IMAGE_WIDTH:     width_r    <= cfg_data[dpb_pkg::SIZE_W-1:0];
          dpb_pkg::CFG_IMAGE_HEIGHT:    height_r   <= cfg_data[dpb_pkg::SIZE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == dpb_pkg::OP_LOAD) begin
        if (col_last) begin
          col_cnt_r   <= '0;
          col_phase_r <= '0;
          if (row_last) begin
            row_cnt_r   <= '0;
            row_phase_r <= '0;
          end else begin
            if (v_p >= m_p) begin
              row_phase_r <= row_phase_adv;
            end
            row_cnt_r <= row_cnt_r + CW'(1);
          end
        end else begin
          if (u_p >= m_p) begin
            col_phase_r <= col_phase_adv;
          end
          col_cnt_r <= col_cnt_r + CW'(1);
        end
      end
    end
  end

  // arithmetic and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      dpb_pkg::OP_LOAD: begin
        d_r <= in_depth_raw;
        u_r <= col_cnt_r;
        v_r <= row_cnt_r;
      end
      dpb_pkg::OP_MUL_D: begin
        mul_r <= mul_prod;
        neg_r <= neg_raw ^ negate;
      end
      dpb_pkg::OP_MUL_LO: begin
        p_r   <= mul_r[PRW-1:0];
        mul_r <= mul_prod;
      end
      dpb_pkg::OP_MUL_HI: begin
        acc_r <= AW'(mul_r);
        mul_r <= mul_prod;
      end
      dpb_pkg::OP_ACC: begin
        acc_r <= acc_r + (AW'(mul_r) << dpb_pkg::INV_HALF_W);
      end
      dpb_pkg::OP_FIN: begin
        if (cmd.axis_y) begin
          res_y_r <= fin;
        end else begin
          res_x_r <= fin;
        end
      end
      dpb_pkg::OP_EMIT: begin
        pt_x_r <= res_x_r;
        pt_y_r <= (FORWARD_AXIS_IS_Y != 0) ? depth_pt : res_y_r;
        pt_z_r <= (FORWARD_AXIS_IS_Y != 0) ? res_y_r : depth_pt;
      end
      default: begin
      end
    endcase
  end

  assign point_x = pt_x_r;
  assign point_y = pt_y_r;
  assign point_z = pt_z_r;

endmodule

`default_nettype wire

### hdl/depth_pixel_backprojection.sv
// depth pixel back-projection top level: dpb_ctrl and dpb_datapath, dpb_pkg, dpb_if.
// a dropped pixel (margin, grid or zero depth) leaves the input free; a kept pixel shows
//   its point after 5 steps per axis on one 32x16 multiplier.
// throughput: 1 pixel per cycle when dropped; a kept pixel holds the input until it is emitted.
// the result register lets the next pixel be taken while a point waits downstream.
// reset (rst_n low, synchronous): counters and phases to zero, configuration registers to defaults.
`default_nettype none
`include "depth_pixel_backprojection_macros.svh"

module depth_pixel_backprojection #(
  parameter int MAX_SIDE          = 2048,
  parameter int FORWARD_AXIS_IS_Y = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_data,
  dpb_in_if.sink                               in_pix,
  dpb_out_if.source                            out_pt
);

  dpb_pkg::cmd_t    cmd;
  dpb_pkg::status_t status;

  dpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_pt.valid),
    .out_ready (out_pt.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dpb_datapath #(
    .MAX_SIDE          (MAX_SIDE),
    .FORWARD_AXIS_IS_Y (FORWARD_AXIS_IS_Y)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_depth_raw (in_pix.depth_raw),
    .cmd          (cmd),
    .status       (status),
    .point_x      (out_pt.point_x),
    .point_y      (out_pt.point_y),
    .point_z      (out_pt.point_z)
  );

  // a kept word blocks the input while its point is computed
  `DPB_ASSERT_NEXT(a_keep_blocks, clk, rst_n, in_pix.valid && in_pix.ready && status.keep, !in_pix.ready)
  // a point is only written into a free output register
  `DPB_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.op == dpb_pkg::OP_EMIT, !out_pt.valid || out_pt.ready)
  `DPB_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.op == dpb_pkg::OP_EMIT, out_pt.valid)
  `DPB_ASSERT_SAME(a_busy_no_accept, clk, rst_n, cmd.op == dpb_pkg::OP_MUL_D || cmd.op == dpb_pkg::OP_FIN, !in_pix.ready)

endmodule

`default_nettype wire

### test/depth_pixel_backprojection_checker.sv
// point checker for the depth pixel back-projection block: tracks the raster position,
// predicts every back-projected point and compares it with the result channel
// depends on dpb_pkg
`timescale 1ns / 1ps

module depth_pixel_backprojection_checker #(
  parameter int MAX_SIDE          = 2048,
  parameter int FORWARD_AXIS_IS_Y = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [dpb_pkg::DEPTH_W-1:0]         in_depth_raw,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [dpb_pkg::POINT_W-1:0]  out_point_x,
  input  logic signed [dpb_pkg::POINT_W-1:0]  out_point_y,
  input  logic signed [dpb_pkg::POINT_W-1:0]  out_point_z,
  output int                                  fail_count,
  output int                                  points_pending
);

  typedef struct packed {
    logic [dpb_pkg::POINT_W-1:0] x;
    logic [dpb_pkg::POINT_W-1:0] y;
    logic [dpb_pkg::POINT_W-1:0] z;
  } point_t;

  point_t expected_points[$];

  logic [dpb_pkg::INV_W-1:0]    fx_inv;
  logic [dpb_pkg::INV_W-1:0]    fy_inv;
  logic [dpb_pkg::CENTER_W-1:0] cx;
  logic [dpb_pkg::CENTER_W-1:0] cy;
  logic [dpb_pkg::MARGIN_W-1:0] margin_reg;
  logic [dpb_pkg::STEP_W-1:0]   step_reg;
  logic [dpb_pkg::SIZE_W-1:0]   width_reg;
  logic [dpb_pkg::SIZE_W-1:0]   height_reg;

  int unsigned col;
  int unsigned row;
  int unsigned col_phase;
  int unsigned row_phase;

  initial begin
    fail_count     = 0;
    points_pending = 0;
  end

  function automatic int unsigned clamp_side(input logic [dpb_pkg::SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return 32'(s);
  endfunction

  function automatic int unsigned step_phase(input int unsigned ph, input int unsigned stp);
    return (ph + 1 >= stp) ? 0 : ph + 1;
  endfunction

  // (pos in q.4 - center) * depth * inverse focal, q.28 rounded half away from zero
  function automatic logic [dpb_pkg::POINT_W-1:0] backproject(
    input int unsigned                  pos,
    input logic [dpb_pkg::CENTER_W-1:0] center,
    input logic [dpb_pkg::DEPTH_W-1:0]  depth,
    input logic [dpb_pkg::INV_W-1:0]    inv,
    input bit                           flip
  );
    logic [63:0] pos_q4;
    logic [63:0] diff;
    logic [63:0] mag;
    logic [63:0] rounded;
    logic [63:0] neg_val;
    bit          negative;
    pos_q4 = 64'(pos);
    pos_q4 = pos_q4 << 4;
    if (pos_q4 >= 64'(center)) begin
      diff     = pos_q4 - 64'(center);
      negative = 1'b0;
    end else begin
      diff     = 64'(center) - pos_q4;
      negative = 1'b1;
    end
    negative = negative ^ flip;
    mag      = diff * 64'(depth) * 64'(inv);
    rounded  = (mag + (64'd1 << (dpb_pkg::FRAC_W - 1))) >> dpb_pkg::FRAC_W;
    if (rounded == 0) return '0;
    if (negative) begin
      if (rounded > 64'(dpb_pkg::OUT_MIN_MAG)) rounded = 64'(dpb_pkg::OUT_MIN_MAG);
      neg_val = 64'd0 - rounded;
      return neg_val[dpb_pkg::POINT_W-1:0];
    end
    if (rounded > 64'(dpb_pkg::OUT_MAX)) rounded = 64'(dpb_pkg::OUT_MAX);
    return rounded[dpb_pkg::POINT_W-1:0];
  endfunction

  task automatic predict_pixel(input logic [dpb_pkg::DEPTH_W-1:0] depth);
    int unsigned w;
    int unsigned h;
    int unsigned stp;
    int unsigned m;
    bit          col_in;
    bit          row_in;
    point_t      pt;
    w   = clamp_side(width_reg);
    h   = clamp_side(height_reg);
    stp = (step_reg == 0) ? 1 :
          ((step_reg > dpb_pkg::STEP_MAX) ? dpb_pkg::STEP_MAX : 32'(step_reg));
    m   = 32'(margin_reg);
    col_in = (col >= m) && (col + m < w);
    row_in = (row >= m) && (row + m < h);
    if (col_in && row_in && col_phase == 0 && row_phase == 0 && depth != 0) begin
      pt.x = backproject(col, cx, depth, fx_inv, 1'b0);
      if (FORWARD_AXIS_IS_Y != 0) begin
        pt.y = dpb_pkg::POINT_W'(depth);
        pt.z = backproject(row, cy, depth, fy_inv, 1'b1);
      end else begin
        pt.y = backproject(row, cy, depth, fy_inv, 1'b0);
        pt.z = dpb_pkg::POINT_W'(depth);
      end
      expected_points = {expected_points, pt};
    end
    // raster advance; counters past a shrunken size wrap here
    if (col + 1 >= w) begin
      col       = 0;
      col_phase = 0;
      if (row + 1 >= h) begin
        row       = 0;
        row_phase = 0;
      end else begin
        if (row >= m) row_phase = step_phase(row_phase, stp);
        row = row + 1;
      end
    end else begin
      if (col >= m) col_phase = step_phase(col_phase, stp);
      col = col + 1;
    end
  endtask

  task automatic check_axis(input string axis, input logic [dpb_pkg::POINT_W-1:0] want,
                            input logic [dpb_pkg::POINT_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: point_%0s mismatch, expected %0d, actual %0d", $time, axis,
               $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      fx_inv     = dpb_pkg::RST_FOCAL_INV;
      fy_inv     = dpb_pkg::RST_FOCAL_INV;
      cx         = dpb_pkg::RST_CENTER_X;
      cy         = dpb_pkg::RST_CENTER_Y;
      margin_reg = dpb_pkg::RST_MARGIN;
      step_reg   = dpb_pkg::RST_STEP;
      width_reg  = dpb_pkg::RST_WIDTH;
      height_reg = dpb_pkg::RST_HEIGHT;
      col        = 0;
      row        = 0;
      col_phase  = 0;
      row_phase  = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dpb_pkg::CFG_FOCAL_X_INV:     fx_inv     = cfg_data[dpb_pkg::INV_W-1:0];
          dpb_pkg::CFG_FOCAL_Y_INV:     fy_inv     = cfg_data[dpb_pkg::INV_W-1:0];
          dpb_pkg::CFG_CENTER_X:        cx         = cfg_data[dpb_pkg::CENTER_W-1:0];
          dpb_pkg::CFG_CENTER_Y:        cy         = cfg_data[dpb_pkg::CENTER_W-1:0];
          dpb_pkg::CFG_BORDER_MARGIN:   margin_reg = cfg_data[dpb_pkg::MARGIN_W-1:0];
          dpb_pkg::CFG_DECIMATION_STEP: step_reg   = cfg_data[dpb_pkg::STEP_W-1:0];
          dpb_pkg::CFG_IMAGE_WIDTH:     width_reg  = cfg_data[dpb_pkg::SIZE_W-1:0];
          dpb_pkg::CFG_IMAGE_HEIGHT:    height_reg = cfg_data[dpb_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected point, expected none, actual (%0d, %0d, %0d)",
                   $time, out_point_x, out_point_y, out_point_z);
        end else begin
          want = expected_points.pop_front();
          check_axis("x", want.x, out_point_x);
          check_axis("y", want.y, out_point_y);
          check_axis("z", want.z, out_point_z);
        end
      end
      if (in_valid && in_ready) predict_pixel(in_depth_raw);
    end
    points_pending = expected_points.size();
  end

endmodule

### test/depth_pixel_backprojection_tb.sv
// testbench top for the depth pixel back-projection block: clock, reset, register
// programming, depth word stimulus and result stalls; checking is in the point checker
// depends on dpb_pkg, dpb_if and depth_pixel_backprojection_checker
`timescale 1ns / 1ps

module depth_pixel_backprojection_tb;

  localparam int NUM_PHASES   = 13;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [16*12-1:0] DIRECTED_DEPTHS = {
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA,
    16'h5555, 16'h0000, 16'hFFFF, 16'h0001, 16'h0064, 16'hFFFF
  };

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data;
  logic [dpb_pkg::CFG_DATA_W-1:0] reg_vals [8];
  bit                             no_idle;
  int                             cycle_count;
  int                             fail_count;
  int                             points_pending;

  dpb_in_if  in_pix();
  dpb_out_if out_pt();

  depth_pixel_backprojection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (in_pix),
    .out_pt    (out_pt)
  );

  depth_pixel_backprojection_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_pix.valid),
    .in_ready       (in_pix.ready),
    .in_depth_raw   (in_pix.depth_raw),
    .out_valid      (out_pt.valid),
    .out_ready      (out_pt.ready),
    .out_point_x    (out_pt.point_x),
    .out_point_y    (out_pt.point_y),
    .out_point_z    (out_pt.point_z),
    .fail_count     (fail_count),
    .points_pending (points_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pt.ready <= 1'b0;
    end else begin
      out_pt.ready <= no_idle || ($urandom_range(0, 99) >= 21);
    end
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("depth_pixel_backprojection_tb failed");
      $finish;
    end
  end

  function automatic logic [dpb_pkg::CFG_DATA_W-1:0] rand_val(input int unsigned lo,
                                                              input int unsigned hi);
    return dpb_pkg::CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  task automatic push_pixel(input logic [dpb_pkg::DEPTH_W-1:0] depth);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 21) begin
        in_pix.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_pix.valid     <= 1'b1;
    in_pix.depth_raw <= depth;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
  endtask

  // hold off the sender until every predicted point has come back
  task automatic wait_drained(input int extra);
    in_pix.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= dpb_pkg::cfg_idx_t'(i);
      cfg_data  <= reg_vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic choose_config(input int p);
    case (p)
      1:       reg_vals[dpb_pkg::CFG_FOCAL_X_INV] = 24'd0;
      3, 7:    reg_vals[dpb_pkg::CFG_FOCAL_X_INV] = 24'hFFFFFF;
      0, 4, 8, 12: reg_vals[dpb_pkg::CFG_FOCAL_X_INV] = rand_val(0, 16777215);
      default: reg_vals[dpb_pkg::CFG_FOCAL_X_INV] = rand_val(20000, 400000);
    endcase
    case (p)
      1:       reg_vals[dpb_pkg::CFG_FOCAL_Y_INV] = 24'd0;
      2:       reg_vals[dpb_pkg::CFG_FOCAL_Y_INV] = 24'hFFFFFF;
      6, 10:   reg_vals[dpb_pkg::CFG_FOCAL_Y_INV] = rand_val(0, 16777215);
      default: reg_vals[dpb_pkg::CFG_FOCAL_Y_INV] = rand_val(20000, 400000);
    endcase
    case (p)
      3:       reg_vals[dpb_pkg::CFG_CENTER_X] = 24'd0;
      7:       reg_vals[dpb_pkg::CFG_CENTER_X] = 24'hFFFF;
      0, 6, 9, 12: reg_vals[dpb_pkg::CFG_CENTER_X] = rand_val(0, 65535);
      default: reg_vals[dpb_pkg::CFG_CENTER_X] = rand_val(0, 400);
    endcase
    case (p)
      6:       reg_vals[dpb_pkg::CFG_CENTER_Y] = 24'd0;
      2:       reg_vals[dpb_pkg::CFG_CENTER_Y] = 24'hFFFF;
      0, 9, 12: reg_vals[dpb_pkg::CFG_CENTER_Y] = rand_val(0, 65535);
      default: reg_vals[dpb_pkg::CFG_CENTER_Y] = rand_val(0, 300);
    endcase
    case (p)
      3:       reg_vals[dpb_pkg::CFG_BORDER_MARGIN] = 24'd0;
      8:       reg_vals[dpb_pkg::CFG_BORDER_MARGIN] = 24'd1023;
      9:       reg_vals[dpb_pkg::CFG_BORDER_MARGIN] = rand_val(1, 6);
      default: reg_vals[dpb_pkg::CFG_BORDER_MARGIN] = rand_val(0, 2);
    endcase
    case (p)
      3:       reg_vals[dpb_pkg::CFG_DECIMATION_STEP] = 24'd1;
      10:      reg_vals[dpb_pkg::CFG_DECIMATION_STEP] = 24'd0;
      11:      reg_vals[dpb_pkg::CFG_DECIMATION_STEP] = 24'd16;
      12:      reg_vals[dpb_pkg::CFG_DECIMATION_STEP] = 24'd31;
      default: reg_vals[dpb_pkg::CFG_DECIMATION_STEP] = rand_val(1, 4);
    endcase
    case (p)
      0:       reg_vals[dpb_pkg::CFG_IMAGE_WIDTH] = 24'd0;
      1:       reg_vals[dpb_pkg::CFG_IMAGE_WIDTH] = 24'd1;
      2:       reg_vals[dpb_pkg::CFG_IMAGE_WIDTH] = 24'd4095;
      3:       reg_vals[dpb_pkg::CFG_IMAGE_WIDTH] = 24'd2048;
      default: reg_vals[dpb_pkg::CFG_IMAGE_WIDTH] = rand_val(2, 24);
    endcase
    case (p)
      3:       reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT] = 24'd2;
      4:       reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT] = 24'd0;
      5:       reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT] = 24'd1;
      6:       reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT] = 24'd4095;
      7:       reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT] = 24'd2048;
      default: reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT] = rand_val(2, 16);
    endcase
  endtask

  initial begin
    int                          n;
    int                          roll;
    logic [dpb_pkg::DEPTH_W-1:0] depth;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_pix.valid     = 1'b0;
    in_pix.depth_raw = '0;
    no_idle          = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few words at the reset settings
    for (int i = 0; i < 4; i++) push_pixel(DIRECTED_DEPTHS[(11 - i) * 16 +: 16]);
    wait_drained(DRAIN_CYCLES);

    // tiny frame with extreme focal and center values
    reg_vals[dpb_pkg::CFG_FOCAL_X_INV]     = 24'hFFFFFF;
    reg_vals[dpb_pkg::CFG_FOCAL_Y_INV]     = 24'd1;
    reg_vals[dpb_pkg::CFG_CENTER_X]        = 24'hFFFF;
    reg_vals[dpb_pkg::CFG_CENTER_Y]        = 24'd0;
    reg_vals[dpb_pkg::CFG_BORDER_MARGIN]   = 24'd0;
    reg_vals[dpb_pkg::CFG_DECIMATION_STEP] = 24'd1;
    reg_vals[dpb_pkg::CFG_IMAGE_WIDTH]     = 24'd4;
    reg_vals[dpb_pkg::CFG_IMAGE_HEIGHT]    = 24'd3;
    program_regs();
    for (int i = 0; i < 12; i++) push_pixel(DIRECTED_DEPTHS[(11 - i) * 16 +: 16]);
    wait_drained(DRAIN_CYCLES);

    for (int p = 0; p < NUM_PHASES; p++) begin
      choose_config(p);
      program_regs();
      no_idle = (p == 5);
      n = (p == 3) ? 250 : ((p == 8) ? 30 : 95);
      for (int i = 0; i < n; i++) begin
        if (p % 2 == 1 && i == n / 2) wait_drained(0);
        roll = $urandom_range(0, 99);
        if (roll < 12) depth = '0;
        else if (roll < 17) depth = 16'hFFFF;
        else if (roll < 20) depth = 16'd1;
        else depth = dpb_pkg::DEPTH_W'($urandom_range(0, 65535));
        push_pixel(depth);
      end
      wait_drained(DRAIN_CYCLES);
    end

    if (fail_count == 0) begin
      $display("depth_pixel_backprojection_tb passed");
    end else begin
      $display("depth_pixel_backprojection_tb failed");
    end
    $finish;
  end

endmodule
